// ===== rtl/core/ndfdg_pkg.sv =====
// Shared types and constants for the N-dimensional gradient block.
// Used by ndfdg_rem and nd_finite_difference_gradient; depends on nothing.
package ndfdg_pkg;

	localparam int MAX_ELEMS   = 4096;
	localparam int MAX_AXES    = 4;
	localparam int SAMPLE_BITS = 16;

	localparam int IDX_BITS    = $clog2(MAX_ELEMS);
	localparam int CNT_BITS    = IDX_BITS + 1;
	localparam int AXIS_BITS   = 2;
	localparam int AXCNT_BITS  = 3;
	localparam int GRAD_BITS   = SAMPLE_BITS + 2;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = CNT_BITS;

	typedef enum logic [0:0] {
		ACT_WRITE = 1'b0,
		ACT_READ  = 1'b1
	} act_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TOTAL_COUNT  = 3'd0,
		REG_AXIS_COUNT   = 3'd1,
		REG_STRIDE_ONE   = 3'd2,
		REG_STRIDE_TWO   = 3'd3,
		REG_STRIDE_THREE = 3'd4,
		REG_STRIDE_FOUR  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_FIRST,
		KIND_LAST,
		KIND_MID
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_OUTER,
		ST_MOD_INNER,
		ST_CLASSIFY,
		ST_READ_HI,
		ST_READ_LO,
		ST_FINISH
	} st_t;

	typedef struct packed {
		logic                start;
		logic [IDX_BITS-1:0] dividend;
		logic [CNT_BITS-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic                done;
		logic [IDX_BITS-1:0] remainder;
	} rem_rsp_t;

endpackage

// ===== rtl/core/ndfdg_rem.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on ndfdg_pkg for widths and the request/response structs.
module ndfdg_rem (
	input  logic                clk,
	input  logic                arst_n,
	input  ndfdg_pkg::rem_req_t req,
	output ndfdg_pkg::rem_rsp_t rsp
);
	import ndfdg_pkg::*;

	localparam int STEP_BITS = $clog2(IDX_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic [IDX_BITS-1:0]  quo_q;
	logic [CNT_BITS-1:0]  div_q;
	logic [CNT_BITS-1:0]  part_q;
	logic [CNT_BITS:0]    trial;
	logic                 fits;
	logic [CNT_BITS-1:0]  part_nxt;

	always_comb begin
		trial    = {part_q, quo_q[IDX_BITS-1]};
		fits     = trial >= {1'b0, div_q};
		part_nxt = fits ? CNT_BITS'(trial - {1'b0, div_q}) : trial[CNT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_BITS'(IDX_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			div_q  <= req.divisor;
			part_q <= '0;
		end else if (busy_q) begin
			quo_q  <= {quo_q[IDX_BITS-2:0], 1'b0};
			part_q <= part_nxt;
		end
	end

	// The partial remainder never exceeds the dividend, so its low bits hold it.
	assign rsp.done      = done_q;
	assign rsp.remainder = part_q[IDX_BITS-1:0];

endmodule

// ===== rtl/core/nd_finite_difference_gradient.sv =====
// Gradient along one axis of a flattened N-dimensional sample array.
// Depends on ndfdg_pkg and the remainder unit ndfdg_rem.
//
//   channel | signals                                          | moves
//   in      | in_valid, in_ready, action, element_index,        | one write or read request
//           | axis_select, sample_value                         |
//   out     | out_valid, out_ready, gradient_value, error_flag  | one result per read request
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data         | one register write
//
// A write request is stored when accepted. A read request runs, in order, two remainder passes
// through the shared bit-serial unit, a classify step, two reads of the single-read-port
// sample store and the output load. A read rejected on its index, axis or extent goes from
// acceptance straight to the output load; one with a neighbour outside the array, after the
// remainder passes and the classify step. Reset sets the configuration registers to one and
// clears the control state and out_valid, but not the context, output data or sample store.
// The output register lets a new request be accepted while a result waits for out_ready.
module nd_finite_difference_gradient (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic                                        action,
	input  logic [ndfdg_pkg::IDX_BITS-1:0]              element_index,
	input  logic [ndfdg_pkg::AXIS_BITS-1:0]             axis_select,
	input  logic signed [ndfdg_pkg::SAMPLE_BITS-1:0]    sample_value,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic signed [ndfdg_pkg::GRAD_BITS-1:0]      gradient_value,
	output logic                                        error_flag,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [ndfdg_pkg::CFG_IDX_BITS-1:0]          cfg_index,
	input  logic [ndfdg_pkg::CFG_DATA_BITS-1:0]         cfg_data
);
	import ndfdg_pkg::*;

	localparam int LIM_BITS = CNT_BITS + 2;

	// Configuration registers.
	logic [CNT_BITS-1:0]   total_count_q;
	logic [AXCNT_BITS-1:0] axis_count_q;
	logic [CNT_BITS-1:0]   stride_q [MAX_AXES];

	// Sample store.
	logic [SAMPLE_BITS-1:0] mem [MAX_ELEMS];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic [IDX_BITS-1:0]    rd_addr;
	logic                   mem_we;

	// Request context.
	st_t                    state_q, state_nxt;
	logic [IDX_BITS-1:0]    m_q;
	logic [CNT_BITS-1:0]    outer_q;
	logic [CNT_BITS-1:0]    inner_q;
	logic [IDX_BITS-1:0]    r_q;
	logic [IDX_BITS-1:0]    base_q;
	kind_t                  kind_q;
	logic                   err_q;
	logic [IDX_BITS-1:0]    addr_hi_q;
	logic [IDX_BITS-1:0]    addr_lo_q;
	logic [SAMPLE_BITS-1:0] hi_q;

	// Output register.
	logic                        out_valid_q;
	logic signed [GRAD_BITS-1:0] gradient_q;
	logic                        error_q;

	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	logic                  accept;
	logic                  accept_read;
	logic [CNT_BITS-1:0]   outer_sel;
	logic [CNT_BITS-1:0]   inner_sel;
	logic                  early_err;
	logic [CNT_BITS-1:0]   up_sum;
	logic [CNT_BITS-1:0]   lo_diff;
	logic                  up_bad;
	logic [LIM_BITS-1:0]   last_lim;
	kind_t                 kind_nxt;
	logic                  class_err;
	logic signed [SAMPLE_BITS:0] diff;
	logic signed [GRAD_BITS-1:0] grad_calc;
	logic                  load_out;

	ndfdg_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// Configuration writes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_count_q <= CNT_BITS'(1);
			axis_count_q  <= AXCNT_BITS'(1);
			for (int k = 0; k < MAX_AXES; k++) begin
				stride_q[k] <= CNT_BITS'(1);
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOTAL_COUNT:  total_count_q <= cfg_data;
				REG_AXIS_COUNT:   axis_count_q  <= cfg_data[AXCNT_BITS-1:0];
				REG_STRIDE_ONE:   stride_q[0]   <= cfg_data;
				REG_STRIDE_TWO:   stride_q[1]   <= cfg_data;
				REG_STRIDE_THREE: stride_q[2]   <= cfg_data;
				REG_STRIDE_FOUR:  stride_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Checks that need only the registers and the request fields.
	always_comb begin
		accept      = in_valid && in_ready;
		accept_read = accept && (action == ACT_READ);
		mem_we      = accept && (action == ACT_WRITE);
		outer_sel   = (axis_select == '0) ? total_count_q
		                                  : stride_q[axis_select - AXIS_BITS'(1)];
		inner_sel   = stride_q[axis_select];
		early_err   = (total_count_q == '0)
		           || (total_count_q > CNT_BITS'(MAX_ELEMS))
		           || ({1'b0, element_index} >= total_count_q)
		           || ({1'b0, axis_select} >= axis_count_q)
		           || (outer_sel == '0) || (inner_sel == '0)
		           || ({1'b0, outer_sel} < {inner_sel, 1'b0});
	end

	// Position class on the axis. base_q is the position times the stride; the element is
	// last on its axis when fewer than two strides remain before the outer stride.
	always_comb begin
		up_sum    = {1'b0, m_q} + inner_q;
		lo_diff   = {1'b0, m_q} - inner_q;
		up_bad    = up_sum >= total_count_q;
		last_lim  = LIM_BITS'(base_q) + LIM_BITS'({inner_q, 1'b0});
		if (base_q == '0) begin
			kind_nxt = KIND_FIRST;
		end else if (LIM_BITS'(outer_q) < last_lim) begin
			kind_nxt = KIND_LAST;
		end else begin
			kind_nxt = KIND_MID;
		end
		class_err = (kind_nxt != KIND_LAST) && up_bad;
	end

	// Difference of the two samples; end points are doubled to keep one fractional bit.
	always_comb begin
		diff = $signed({hi_q[SAMPLE_BITS-1], hi_q}) - $signed({rd_data_q[SAMPLE_BITS-1], rd_data_q});
		if (kind_q == KIND_MID) begin
			grad_calc = {diff[SAMPLE_BITS], diff};
		end else begin
			grad_calc = {diff, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt        = state_q;
		in_ready         = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = element_index;
		rem_req.divisor  = outer_sel;
		rd_addr          = addr_lo_q;
		load_out         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept_read) begin
					if (early_err) begin
						state_nxt = ST_FINISH;
					end else begin
						rem_req.start = 1'b1;
						state_nxt     = ST_MOD_OUTER;
					end
				end
			end
			ST_MOD_OUTER: begin
				rem_req.dividend = rem_rsp.remainder;
				rem_req.divisor  = inner_q;
				if (rem_rsp.done) begin
					rem_req.start = 1'b1;
					state_nxt     = ST_MOD_INNER;
				end
			end
			ST_MOD_INNER: begin
				if (rem_rsp.done) begin
					state_nxt = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				state_nxt = class_err ? ST_FINISH : ST_READ_HI;
			end
			ST_READ_HI: begin
				rd_addr   = addr_hi_q;
				state_nxt = ST_READ_LO;
			end
			ST_READ_LO: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[element_index] <= sample_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept_read) begin
			m_q     <= element_index;
			outer_q <= outer_sel;
			inner_q <= inner_sel;
			err_q   <= early_err;
		end
		if (state_q == ST_MOD_OUTER && rem_rsp.done) begin
			r_q <= rem_rsp.remainder;
		end
		if (state_q == ST_MOD_INNER && rem_rsp.done) begin
			base_q <= r_q - rem_rsp.remainder;
		end
		if (state_q == ST_CLASSIFY) begin
			kind_q    <= kind_nxt;
			err_q     <= class_err;
			addr_hi_q <= (kind_nxt == KIND_LAST) ? m_q : up_sum[IDX_BITS-1:0];
			addr_lo_q <= (kind_nxt == KIND_FIRST) ? m_q : lo_diff[IDX_BITS-1:0];
		end
		if (state_q == ST_READ_LO) begin
			hi_q <= rd_data_q;
		end
		if (load_out) begin
			gradient_q <= err_q ? '0 : grad_calc;
			error_q    <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign gradient_value = gradient_q;
	assign error_flag     = error_q;

	// The remainder unit answers only while a read waits for it.
	a_rem_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> (state_q == ST_MOD_OUTER || state_q == ST_MOD_INNER))
		else $error("remainder unit finished outside a remainder state");

	// Both samples of a read that passes classification lie inside the array.
	a_addr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ_HI) |-> ({1'b0, addr_hi_q} < total_count_q
			&& {1'b0, addr_lo_q} < total_count_q))
		else $error("sample read outside the array");

	// A rejected read carries a zero gradient.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_flag) |-> (gradient_value == '0))
		else $error("rejected read carries a nonzero gradient");

	// A result is loaded only once the previous one has been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && out_valid_q) |-> out_ready)
		else $error("result overwritten before it was taken");

endmodule
